FILE: sv/detection_temporal_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// detection_temporal_tracker_unit_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DETECTION_TEMPORAL_TRACKER_UNIT_ASSERT_SVH
`define DETECTION_TEMPORAL_TRACKER_UNIT_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define DTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A signal keeps its value on the edge after the condition holds.
`define DTT_ASSERT_STABLE(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

FILE: sv/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the detection tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package dtt_pkg;
  localparam int unsigned DefMaxTracked = 32;
  localparam int unsigned DefCoordBits  = 14;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 17;

  localparam logic [CfgIdxW-1:0] RegTol    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSmooth = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVis    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHid    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFrameW = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFrameH = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;    // capture the input beat
    logic frame_start;// record emptiness, clear matched flags
    logic rd;         // read entry at rd pointer
    logic cmp;        // evaluate read entry against the held detection
    logic upd;        // write back matched entry
    logic ins;        // append the held detection
    logic age;        // age read entry and compact it
    logic age_done;   // commit the new entry count
    logic emit;       // load output register from read entry
    logic emit_empty; // load output register with empty marker
    logic emit_last;  // set last on the emitted beat
    logic clr_ptr;    // reset read and write pointers
  } dtt_cmd_t;

  typedef struct packed {
    logic is_eof;
    logic frame_open;
    logic ptr_end;    // read pointer reached entry count
    logic hit;        // compared entry matched
    logic full;
    logic hidden;     // read entry is hidden
    logic any_shown;  // an entry was emitted this end of frame
    logic last_shown; // one visible entry is left to emit
  } dtt_sts_t;
endpackage
`default_nettype wire

FILE: sv/dtt_datapath.sv
// ----------------------------------------------------------------------------
// dtt_datapath
// Entry table, match test, smoothing, ageing and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_datapath import dtt_pkg::*; #(
  parameter int unsigned MaxTracked = DefMaxTracked,
  parameter int unsigned CoordBits  = DefCoordBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dtt_cmd_t             cmd_i,
  output dtt_sts_t                  sts_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 func_i,
  input  wire logic [7:0]           category_i,
  input  wire logic [15:0]          confidence_i,
  input  wire logic signed [CoordBits-1:0] box_x_i,
  input  wire logic signed [CoordBits-1:0] box_y_i,
  input  wire logic [CoordBits-2:0] box_w_i,
  input  wire logic [CoordBits-2:0] box_h_i,
  output logic                      has_object_o,
  output logic [7:0]                obj_category_o,
  output logic [15:0]               obj_confidence_o,
  output logic signed [CoordBits-1:0] obj_x_o,
  output logic signed [CoordBits-1:0] obj_y_o,
  output logic [CoordBits-2:0]      obj_w_o,
  output logic [CoordBits-2:0]      obj_h_o,
  output logic                      last_o
);
  localparam int unsigned IdxW = $clog2(MaxTracked);
  localparam int unsigned CntW = $clog2(MaxTracked + 1);
  localparam int unsigned ProdW = 30;

  typedef struct packed {
    logic [7:0]                  cls;
    logic [15:0]                 score;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [CoordBits-2:0]        w;
    logic [CoordBits-2:0]        h;
    logic [7:0]                  vis;
    logic [7:0]                  hid;
  } ent_t;

  // Configuration registers.
  logic [15:0] tol_q;
  logic [16:0] smooth_q;
  logic [7:0]  vis_q, hid_q;
  logic [12:0] fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= 16'd3277;
      smooth_q <= 17'd13107;
      vis_q    <= 8'd5;
      hid_q    <= 8'd2;
      fw_q     <= 13'd640;
      fh_q     <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTol:    tol_q    <= cfg_data_i[15:0];
        RegSmooth: smooth_q <= cfg_data_i;
        RegVis:    vis_q    <= cfg_data_i[7:0];
        RegHid:    hid_q    <= cfg_data_i[7:0];
        RegFrameW: fw_q     <= cfg_data_i[12:0];
        RegFrameH: fh_q     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Tolerance thresholds, registered unconditionally from the tolerance and frame size.
  logic [28:0] thr_w_q, thr_h_q;
  always_ff @(posedge clk_i) begin
    thr_w_q <= 29'(tol_q) * 29'(fw_q);
    thr_h_q <= 29'(tol_q) * 29'(fh_q);
  end

  logic [16:0] f_eff;
  assign f_eff = smooth_q[16] ? 17'h10000 : smooth_q;

  // Held input beat.
  logic       eof_q;
  ent_t       in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      eof_q    <= func_i;
      in_q.cls <= category_i;
      in_q.score <= confidence_i;
      in_q.x   <= box_x_i;
      in_q.y   <= box_y_i;
      in_q.w   <= box_w_i;
      in_q.h   <= box_h_i;
      in_q.vis <= vis_q;
      in_q.hid <= 8'd0;
    end
  end

  // Table memory, one read and one write port.
  ent_t mem [MaxTracked];
  logic [MaxTracked-1:0] matched_q;
  ent_t rd_q;
  logic [CntW-1:0] cnt_q, rp_q, wp_q, rp_hold_q;
  logic [CntW-1:0] vis_cnt_q;  // visible entries not yet emitted
  logic            frame_open_q, was_empty_q, shown_q;
  logic            we;
  logic [IdxW-1:0] wa;
  ent_t            wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[rp_q[IdxW-1:0]];
    if (we) mem[wa] <= wd;
  end

  // Match test on the read entry.
  function automatic logic near(input logic signed [CoordBits:0] a,
                                input logic signed [CoordBits:0] b,
                                input logic [28:0] thr);
    logic signed [CoordBits+1:0] d;
    logic [CoordBits+1:0] ad;
    d  = (CoordBits+2)'(a) - (CoordBits+2)'(b);
    ad = d[CoordBits+1] ? (CoordBits+2)'(-d) : (CoordBits+2)'(d);
    return ({ad, 16'd0} < {(CoordBits+2)'(0), thr} ) ;
  endfunction

  logic hit;
  assign hit = (rd_q.cls == in_q.cls)
    && near((CoordBits+1)'(in_q.x), (CoordBits+1)'(rd_q.x), thr_w_q)
    && near((CoordBits+1)'(in_q.y), (CoordBits+1)'(rd_q.y), thr_h_q)
    && near((CoordBits+1)'({1'b0, in_q.w}), (CoordBits+1)'({1'b0, rd_q.w}), thr_w_q)
    && near((CoordBits+1)'({1'b0, in_q.h}), (CoordBits+1)'({1'b0, rd_q.h}), thr_h_q);

  // Smoothing: ov + f*(nv-ov)/65536 truncated toward zero, registered.
  function automatic logic signed [CoordBits:0] smooth(
      input logic signed [CoordBits:0] nv, input logic signed [CoordBits:0] ov,
      input logic [16:0] f);
    logic signed [ProdW+CoordBits:0] num;
    logic signed [ProdW+CoordBits:0] q;
    num = $signed({1'b0, f}) * nv + $signed(18'sh10000 - $signed({1'b0, f})) * ov;
    q = num >>> 16;
    if (num < 0 && num[15:0] != 16'd0) q = q + 1;
    return (CoordBits+1)'(q);
  endfunction

  ent_t upd_q;
  always_ff @(posedge clk_i) begin
    upd_q.cls   <= rd_q.cls;
    upd_q.score <= in_q.score;
    upd_q.x <= CoordBits'(smooth((CoordBits+1)'(in_q.x), (CoordBits+1)'(rd_q.x), f_eff));
    upd_q.y <= CoordBits'(smooth((CoordBits+1)'(in_q.y), (CoordBits+1)'(rd_q.y), f_eff));
    upd_q.w <= (CoordBits-1)'(smooth((CoordBits+1)'({1'b0, in_q.w}),
                                     (CoordBits+1)'({1'b0, rd_q.w}), f_eff));
    upd_q.h <= (CoordBits-1)'(smooth((CoordBits+1)'({1'b0, in_q.h}),
                                     (CoordBits+1)'({1'b0, rd_q.h}), f_eff));
    upd_q.vis <= vis_q;
    upd_q.hid <= (rd_q.hid != 8'd0) ? rd_q.hid - 8'd1 : 8'd0;
  end

  // Ageing of the read entry.
  logic [IdxW-1:0] ri;
  logic            rm;
  logic [7:0]      aged_vis;
  ent_t            aged;
  assign ri = rp_hold_q[IdxW-1:0];
  assign rm = matched_q[ri];
  always_comb begin
    aged_vis = rd_q.vis;
    if (!rm) begin
      if (rd_q.hid != 8'd0) aged_vis = 8'd0;
      else if (rd_q.vis != 8'd0) aged_vis = rd_q.vis - 8'd1;
    end
    aged = rd_q;
    aged.vis = aged_vis;
  end

  always_comb begin
    we = 1'b0;
    wa = ri;
    wd = upd_q;
    if (cmd_i.upd) begin
      we = 1'b1;
    end else if (cmd_i.ins) begin
      we = 1'b1;
      wa = cnt_q[IdxW-1:0];
      wd = in_q;
      wd.hid = was_empty_q ? 8'd0 : hid_q;
    end else if (cmd_i.age) begin
      we = rm || (aged_vis != 8'd0);
      wa = wp_q[IdxW-1:0];
      wd = aged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rp_q <= '0; wp_q <= '0; rp_hold_q <= '0; vis_cnt_q <= '0;
      matched_q <= '0; frame_open_q <= 1'b0; was_empty_q <= 1'b1; shown_q <= 1'b0;
    end else begin
      if (cmd_i.frame_start) begin
        frame_open_q <= 1'b1;
        was_empty_q  <= (cnt_q == '0);
        matched_q    <= '0;
      end
      if (cmd_i.clr_ptr) begin
        rp_q <= '0; wp_q <= '0; shown_q <= 1'b0;
      end
      if (cmd_i.rd) begin
        rp_hold_q <= rp_q;
        rp_q <= rp_q + CntW'(1);
      end
      if (cmd_i.upd) matched_q[ri] <= 1'b1;
      if (cmd_i.ins) begin
        matched_q[cnt_q[IdxW-1:0]] <= 1'b1;
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.age && we) begin
        matched_q[wp_q[IdxW-1:0]] <= rm;
        wp_q <= wp_q + CntW'(1);
        // Kept entries that are not hidden are emitted in the pass that follows.
        if (rd_q.hid == 8'd0) vis_cnt_q <= vis_cnt_q + CntW'(1);
      end
      if (cmd_i.age_done) begin
        cnt_q <= wp_q;
        frame_open_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        shown_q   <= 1'b1;
        vis_cnt_q <= vis_cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      has_object_o     <= 1'b1;
      obj_category_o   <= rd_q.cls;
      obj_confidence_o <= rd_q.score;
      obj_x_o          <= rd_q.x;
      obj_y_o          <= rd_q.y;
      obj_w_o          <= rd_q.w;
      obj_h_o          <= rd_q.h;
      last_o           <= cmd_i.emit_last;
    end else if (cmd_i.emit_empty) begin
      has_object_o     <= 1'b0;
      obj_category_o   <= '0;
      obj_confidence_o <= '0;
      obj_x_o          <= '0;
      obj_y_o          <= '0;
      obj_w_o          <= '0;
      obj_h_o          <= '0;
      last_o           <= 1'b1;
    end
  end

  always_comb begin
    sts_o.is_eof     = eof_q;
    sts_o.frame_open = frame_open_q;
    sts_o.ptr_end    = (rp_q == cnt_q);
    sts_o.hit        = hit;
    sts_o.full       = (cnt_q == CntW'(MaxTracked));
    sts_o.hidden     = (rd_q.hid != 8'd0);
    sts_o.any_shown  = shown_q;
    sts_o.last_shown = (vis_cnt_q == CntW'(1));
  end
endmodule
`default_nettype wire

FILE: sv/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer for the match scan, ageing pass and emission pass.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_ctrl import dtt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dtt_sts_t sts_i,
  output dtt_cmd_t      cmd_o
);
  typedef enum logic [11:0] {
    SIdle  = 12'b000000000001, SStart = 12'b000000000010,
    SMRd   = 12'b000000000100, SMCmp  = 12'b000000001000,
    SMSm   = 12'b000000010000, SMWr   = 12'b000000100000,
    SARd   = 12'b000001000000, SAWr   = 12'b000010000000,
    SERd   = 12'b000100000000, SEChk  = 12'b001000000000,
    SOut   = 12'b010000000000, SPend  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;     // output register holds an unaccepted beat

  // The datapath counts the visible entries left, which marks the last beat.
  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = SStart;
        end
      end
      SStart: begin
        cmd_o.frame_start = !sts_i.frame_open;
        cmd_o.clr_ptr = 1'b1;
        state_d = sts_i.is_eof ? SARd : SMRd;
      end
      SMRd: begin
        if (sts_i.ptr_end) begin
          if (!sts_i.full) cmd_o.ins = 1'b1;
          state_d = SIdle;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = SMCmp;
        end
      end
      SMCmp: state_d = sts_i.hit ? SMSm : SMRd;
      SMSm:  state_d = SMWr;
      SMWr: begin
        cmd_o.upd = 1'b1;
        state_d = SIdle;
      end
      SARd: begin
        if (sts_i.ptr_end) begin
          cmd_o.age_done = 1'b1;
          state_d = SPend;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = SAWr;
        end
      end
      SAWr: begin
        cmd_o.age = 1'b1;
        state_d = SARd;
      end
      SPend: begin
        cmd_o.clr_ptr = 1'b1;
        state_d = SERd;
      end
      SERd: begin
        if (sts_i.ptr_end) begin
          if (sts_i.any_shown) begin
            state_d = SIdle;
          end else if (!ov_d) begin
            cmd_o.emit_empty = 1'b1;
            ov_d = 1'b1;
            state_d = SIdle;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d = SEChk;
        end
      end
      SEChk: state_d = sts_i.hidden ? SERd : SOut;
      SOut: begin
        // Wait until the output register is free.
        if (!ov_d) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_last = sts_i.last_shown;
          ov_d = 1'b1;
          state_d = SERd;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/detection_temporal_tracker_unit.sv
// ----------------------------------------------------------------------------
// detection_temporal_tracker_unit
// Temporal tracker of object detections over a table of tracked entries.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  func .. box_h
// out       output     out_valid_o/out_ready_i has_object .. last
// cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
// A detection reads the entries one after another until one matches or
// none is left; a hit is written back, a miss is appended if there is room.
// An end of frame ages every entry and keeps some of them, then emits each
// visible entry, waiting on any output stall.
// The table's single read port makes each pass visit one entry at a time.
// Reset empties the table at once; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module detection_temporal_tracker_unit import dtt_pkg::*; #(
  parameter int unsigned MaxTracked = DefMaxTracked,
  parameter int unsigned CoordBits  = DefCoordBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0]         cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        func_i,
  input  wire logic [7:0]                  category_i,
  input  wire logic [15:0]                 confidence_i,
  input  wire logic signed [CoordBits-1:0] box_x_i,
  input  wire logic signed [CoordBits-1:0] box_y_i,
  input  wire logic [CoordBits-2:0]        box_w_i,
  input  wire logic [CoordBits-2:0]        box_h_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             has_object_o,
  output logic [7:0]                       obj_category_o,
  output logic [15:0]                      obj_confidence_o,
  output logic signed [CoordBits-1:0]      obj_x_o,
  output logic signed [CoordBits-1:0]      obj_y_o,
  output logic [CoordBits-2:0]             obj_w_o,
  output logic [CoordBits-2:0]             obj_h_o,
  output logic                             last_o
);
  dtt_cmd_t cmd;
  dtt_sts_t sts;
  logic     last_raw;

  dtt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dtt_datapath #(.MaxTracked(MaxTracked), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .func_i, .category_i, .confidence_i, .box_x_i, .box_y_i, .box_w_i, .box_h_i,
    .has_object_o, .obj_category_o, .obj_confidence_o, .obj_x_o, .obj_y_o,
    .obj_w_o, .obj_h_o, .last_o(last_raw)
  );

  assign last_o = last_raw;
endmodule
`default_nettype wire

FILE: sv/dtt_checker.sv
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "detection_temporal_tracker_unit_assert.svh"
module dtt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic has_object_o,
  input wire logic last_o
);
  `DTT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output dropped")
  `DTT_ASSERT_STABLE(a_has_stable, out_valid_o && !out_ready_i, has_object_o, "payload moved")
  `DTT_ASSERT_STABLE(a_last_stable, out_valid_o && !out_ready_i, last_o, "last moved")
  `DTT_ASSERT(a_empty_last, out_valid_o && !has_object_o |-> last_o, "empty not last")
endmodule

bind detection_temporal_tracker_unit dtt_checker u_dtt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .has_object_o, .last_o
);
`default_nettype wire
